// ----- hw/rtl/mh64_pkg.sv -----
package mh64_pkg;

    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT = 47;

    localparam int SEED_W   = 32;
    localparam int LEN_W    = 31;
    localparam int WORD_W   = 64;
    localparam int NBYTES_W = 4;
    localparam int WORD_BYTES = WORD_W / 8;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_TAIL = 2'd1,
        OP_FULL = 2'd2
    } t_op;

    typedef struct packed {
        logic              first;
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] data;
        t_op               op;
        logic              last;
    } t_entry;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] operand;
    } t_mul_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] product;
    } t_mul_rsp;

    function automatic logic [WORD_W-1:0] xor_shift(input logic [WORD_W-1:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

endpackage

// ----- hw/rtl/mh64_front.sv -----
module mh64_front (
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_first_word,
    input  logic [mh64_pkg::LEN_W-1:0]    i_message_length,
    input  logic [mh64_pkg::WORD_W-1:0]   i_data_word,
    input  logic [mh64_pkg::NBYTES_W-1:0] i_valid_bytes,
    input  logic                          i_last_word,
    input  logic                          i_full,
    output logic                          o_push,
    output mh64_pkg::t_entry              o_entry
);
    import mh64_pkg::*;

    logic [WORD_W-1:0] w_masked;

    // drop bytes above the valid count for a tail transaction
    always_comb begin
        for (int b = 0; b < WORD_BYTES; b++) begin
            w_masked[8*b +: 8] = (i_valid_bytes > NBYTES_W'(b)) ? i_data_word[8*b +: 8] : 8'h00;
        end
    end

    always_comb begin
        o_entry.first = i_first_word;
        o_entry.len   = i_message_length;
        o_entry.last  = i_last_word;
        if (i_valid_bytes >= NBYTES_W'(WORD_BYTES)) begin
            o_entry.op   = OP_FULL;
            o_entry.data = i_data_word;
        end else if (i_valid_bytes == '0) begin
            o_entry.op   = OP_NONE;
            o_entry.data = '0;
        end else begin
            o_entry.op   = OP_TAIL;
            o_entry.data = w_masked;
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// ----- hw/rtl/mh64_queue.sv -----
module mh64_queue #(
    parameter int DEPTH = mh64_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mh64_pkg::t_entry i_entry,
    input  logic             i_pop,
    output mh64_pkg::t_entry o_entry,
    output logic             o_full,
    output logic             o_empty
);
    import mh64_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != CNT_W'(DEPTH))
        else $error("queue pushed while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

// ----- hw/rtl/mh64_mul.sv -----
module mh64_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mh64_pkg::t_mul_req i_req,
    output mh64_pkg::t_mul_rsp o_rsp
);
    import mh64_pkg::*;

    // low 64 bits of x * MIX_MUL from three 32x32 partial products on one multiplier
    localparam logic [31:0] M_LO = MIX_MUL[31:0];
    localparam logic [31:0] M_HI = MIX_MUL[63:32];

    localparam logic [1:0] PH_LO      = 2'd0;
    localparam logic [1:0] PH_CROSS_A = 2'd1;
    localparam logic [1:0] PH_CROSS_B = 2'd2;
    localparam logic [1:0] PH_SUM     = 2'd3;

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_phase;
    logic [WORD_W-1:0] r_x;
    logic [63:0]       r_p0;
    logic [31:0]       r_cross;
    logic [WORD_W-1:0] r_prod;

    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_mul_p;

    always_comb begin
        w_mul_a = (r_phase == PH_CROSS_A) ? r_x[63:32] : r_x[31:0];
        w_mul_b = (r_phase == PH_CROSS_B) ? M_HI : M_LO;
        w_mul_p = w_mul_a * w_mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= PH_LO;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy  <= 1'b1;
                    r_phase <= PH_LO;
                end
            end else begin
                r_phase <= r_phase + 1'b1;
                if (r_phase == PH_SUM) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_x <= i_req.operand;
        end
        if (r_busy) begin
            case (r_phase)
                PH_LO:      r_p0    <= w_mul_p;
                PH_CROSS_A: r_cross <= w_mul_p[31:0];
                PH_CROSS_B: r_cross <= r_cross + w_mul_p[31:0];
                PH_SUM:     r_prod  <= r_p0 + {r_cross, 32'h0};
                default:    r_prod  <= r_prod;
            endcase
        end
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_prod;

endmodule

// ----- hw/rtl/mh64_back.sv -----
module mh64_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mh64_pkg::SEED_W-1:0]   i_seed,
    input  logic                          i_empty,
    input  mh64_pkg::t_entry              i_entry,
    output logic                          o_pop,
    output mh64_pkg::t_mul_req            o_mul_req,
    input  mh64_pkg::t_mul_rsp            i_mul_rsp,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mh64_pkg::WORD_W-1:0]   o_hash_value
);
    import mh64_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INIT_W = 4'd1;
    localparam logic [3:0] ST_ABSORB = 4'd2;
    localparam logic [3:0] ST_K1_W   = 4'd3;
    localparam logic [3:0] ST_K2_W   = 4'd4;
    localparam logic [3:0] ST_ACC_W  = 4'd5;
    localparam logic [3:0] ST_FIN    = 4'd6;
    localparam logic [3:0] ST_FIN_W  = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [WORD_W-1:0] r_acc, n_acc;
    t_entry            r_item, n_item;
    logic [WORD_W-1:0] r_hash, n_hash;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_hash, n_out_hash;

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_item      = r_item;
        n_hash      = r_hash;
        n_out_valid = r_out_valid;
        n_out_hash  = r_out_hash;
        o_pop       = 1'b0;
        o_mul_req   = '0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_item = i_entry;
                    if (i_entry.first) begin
                        o_mul_req.start   = 1'b1;
                        o_mul_req.operand = {{(WORD_W-LEN_W){1'b0}}, i_entry.len};
                        n_state           = ST_INIT_W;
                    end else begin
                        n_state = ST_ABSORB;
                    end
                end
            end
            ST_INIT_W: begin
                if (i_mul_rsp.done) begin
                    n_acc   = {{(WORD_W-SEED_W){1'b0}}, i_seed} ^ i_mul_rsp.product;
                    n_state = ST_ABSORB;
                end
            end
            ST_ABSORB: begin
                case (r_item.op)
                    OP_FULL: begin
                        o_mul_req.start   = 1'b1;
                        o_mul_req.operand = r_item.data;
                        n_state           = ST_K1_W;
                    end
                    OP_TAIL: begin
                        o_mul_req.start   = 1'b1;
                        o_mul_req.operand = r_acc ^ r_item.data;
                        n_state           = ST_ACC_W;
                    end
                    default: begin
                        n_state = ST_FIN;
                    end
                endcase
            end
            ST_K1_W: begin
                if (i_mul_rsp.done) begin
                    o_mul_req.start   = 1'b1;
                    o_mul_req.operand = xor_shift(i_mul_rsp.product);
                    n_state           = ST_K2_W;
                end
            end
            ST_K2_W: begin
                if (i_mul_rsp.done) begin
                    o_mul_req.start   = 1'b1;
                    o_mul_req.operand = r_acc ^ i_mul_rsp.product;
                    n_state           = ST_ACC_W;
                end
            end
            ST_ACC_W: begin
                if (i_mul_rsp.done) begin
                    n_acc   = i_mul_rsp.product;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // finalization works on a copy, the accumulator stays unfinalized
                if (r_item.last) begin
                    o_mul_req.start   = 1'b1;
                    o_mul_req.operand = xor_shift(r_acc);
                    n_state           = ST_FIN_W;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FIN_W: begin
                if (i_mul_rsp.done) begin
                    n_hash  = xor_shift(i_mul_rsp.product);
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = r_hash;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_hash     <= n_hash;
        r_out_hash <= n_out_hash;
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out_hash;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mul_rsp.done |-> (r_state == ST_INIT_W || r_state == ST_K1_W ||
                            r_state == ST_K2_W || r_state == ST_ACC_W ||
                            r_state == ST_FIN_W))
        else $error("multiply result arrived outside a wait state");

    a_start_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mul_req.start |-> !i_mul_rsp.busy)
        else $error("multiply started while busy");

    a_emit_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_EMIT))
        else $error("result raised outside the emit step");

endmodule

// ----- hw/rtl/murmur64a_hash_stream_top.sv -----
// MurmurHash64A over a stream of little-endian 64-bit words. Each transaction carries one
// word with its valid byte count; the first transaction of a message also carries the total
// length, and the last one produces the 64-bit hash. The user must write the 32-bit seed through
// i_hash_seed_we / i_hash_seed only while the block is idle; the block does not enforce this.
// Transactions land in a short queue and are worked off one at a time by a sequencer around
// a single 32x32 multiplier, which forms each 64-bit multiply by the mixing constant. A full
// word takes three such multiplies, a tail word one, the first word of a message one more
// and the last word one more.
module murmur64a_hash_stream_top #(
    parameter int QUEUE_DEPTH = mh64_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_hash_seed_we,
    input  logic [mh64_pkg::SEED_W-1:0]   i_hash_seed,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_first_word,
    input  logic [mh64_pkg::LEN_W-1:0]    i_message_length,
    input  logic [mh64_pkg::WORD_W-1:0]   i_data_word,
    input  logic [mh64_pkg::NBYTES_W-1:0] i_valid_bytes,
    input  logic                          i_last_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mh64_pkg::WORD_W-1:0]   o_hash_value
);
    import mh64_pkg::*;

    logic [SEED_W-1:0] r_hash_seed;

    logic     w_push;
    logic     w_pop;
    logic     w_full;
    logic     w_empty;
    t_entry   w_in_entry;
    t_entry   w_head;
    t_mul_req w_mul_req;
    t_mul_rsp w_mul_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_seed <= '0;
        end else if (i_hash_seed_we) begin
            r_hash_seed <= i_hash_seed;
        end
    end

    mh64_front u_front (
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_first_word     (i_first_word),
        .i_message_length (i_message_length),
        .i_data_word      (i_data_word),
        .i_valid_bytes    (i_valid_bytes),
        .i_last_word      (i_last_word),
        .i_full           (w_full),
        .o_push           (w_push),
        .o_entry          (w_in_entry)
    );

    mh64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .i_pop   (w_pop),
        .o_entry (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    mh64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    mh64_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_hash_seed),
        .i_empty      (w_empty),
        .i_entry      (w_head),
        .o_pop        (w_pop),
        .o_mul_req    (w_mul_req),
        .i_mul_rsp    (w_mul_rsp),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value)
    );

endmodule

// ----- test/murmur64a_hash_stream_top_tb.sv -----
`timescale 1ns / 100ps

module murmur64a_hash_stream_top_tb;

    import mh64_pkg::*;

    localparam int N_DIRECTED     = 20;
    localparam int N_PHASES       = 6;
    localparam int ITEMS_PER_PHASE = 255;
    localparam int IDLE_WAIT      = 120;
    localparam int MAX_STALL_RUN  = 12;

    typedef struct packed {
        logic                first;
        logic [LEN_W-1:0]    len;
        logic [WORD_W-1:0]   data;
        logic [NBYTES_W-1:0] nbytes;
        logic                last;
        logic                golden_en;
        logic [WORD_W-1:0]   golden;
    } t_word_txn;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_hash_seed_we = 1'b0;
    logic [SEED_W-1:0]   i_hash_seed = '0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic                i_first_word = 1'b0;
    logic [LEN_W-1:0]    i_message_length = '0;
    logic [WORD_W-1:0]   i_data_word = '0;
    logic [NBYTES_W-1:0] i_valid_bytes = '0;
    logic                i_last_word = 1'b0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [WORD_W-1:0]   o_hash_value;

    // golden value typed into the directed table, used instead of the predictor
    logic                cur_golden_en = 1'b0;
    logic [WORD_W-1:0]   cur_golden = '0;

    logic [SEED_W-1:0]   seed_shadow = '0;
    logic [WORD_W-1:0]   msg_acc = '0;
    logic [WORD_W-1:0]   hash_expected [$];
    int                  fail_count = 0;
    int                  burst_left = 0;

    t_word_txn           directed_tbl [N_DIRECTED];

    murmur64a_hash_stream_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_hash_seed_we   (i_hash_seed_we),
        .i_hash_seed      (i_hash_seed),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_first_word     (i_first_word),
        .i_message_length (i_message_length),
        .i_data_word      (i_data_word),
        .i_valid_bytes    (i_valid_bytes),
        .i_last_word      (i_last_word),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hash_value     (o_hash_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver stall pattern, mode re-drawn at random when its run ends
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_mode_left = 0;
    int          stall_run = 0;
    int          stall_phase = 0;

    always @(negedge i_clk) begin
        logic s;
        if (stall_mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(50, 300);
        end
        stall_mode_left--;
        stall_phase = (stall_phase + 1) % 5;
        case (stall_mode)
            STALL_NONE:  s = 1'b0;
            STALL_LIGHT: s = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: s = ($urandom_range(0, 3) != 0);
            default:     s = (stall_phase < 3);
        endcase
        if (stall_run >= MAX_STALL_RUN)
            s = 1'b0;
        stall_run = s ? stall_run + 1 : 0;
        i_stall <= s;
    end

    // hash predictor and result check
    always @(posedge i_clk) begin
        logic [WORD_W-1:0] k;
        logic [WORD_W-1:0] h;
        int unsigned       nb;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (hash_expected.size() == 0) begin
                    $error("hash_value with no expected transaction: actual %h", o_hash_value);
                    fail_count++;
                end else begin
                    h = hash_expected.pop_front();
                    if (o_hash_value !== h) begin
                        $error("hash_value mismatch: expected %h, actual %h", h, o_hash_value);
                        fail_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                if (i_first_word)
                    msg_acc = {{(WORD_W-SEED_W){1'b0}}, seed_shadow}
                              ^ (WORD_W'(i_message_length) * MIX_MUL);
                nb = {28'd0, i_valid_bytes};
                if (nb >= WORD_BYTES) begin
                    k = i_data_word * MIX_MUL;
                    k = k ^ (k >> MIX_SHIFT);
                    k = k * MIX_MUL;
                    msg_acc = (msg_acc ^ k) * MIX_MUL;
                end else if (nb != 0) begin
                    // bytes above the count are dropped
                    msg_acc = (msg_acc ^ (i_data_word & ((64'd1 << (nb * 8)) - 64'd1))) * MIX_MUL;
                end
                if (i_last_word) begin
                    // finalization works on a copy, the accumulator is kept
                    h = msg_acc ^ (msg_acc >> MIX_SHIFT);
                    h = h * MIX_MUL;
                    h = h ^ (h >> MIX_SHIFT);
                    hash_expected.push_back(cur_golden_en ? cur_golden : h);
                end
            end
        end
    end

    task automatic scramble_payload();
        i_first_word = 1'($urandom);
        i_message_length = LEN_W'($urandom);
        i_data_word = {$urandom, $urandom};
        i_valid_bytes = NBYTES_W'($urandom);
        i_last_word = 1'($urandom);
    endtask

    task automatic send_txn(input t_word_txn t);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                cur_golden_en = 1'b0;
                scramble_payload();
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_first_word = t.first;
        i_message_length = t.len;
        i_data_word = t.data;
        i_valid_bytes = t.nbytes;
        i_last_word = t.last;
        cur_golden_en = t.golden_en;
        cur_golden = t.golden;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        burst_left--;
    endtask

    task automatic settle_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        cur_golden_en = 1'b0;
        burst_left = 0;
        while (hash_expected.size() != 0)
            @(posedge i_clk);
        // a message left open may still be in the datapath
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [SEED_W-1:0] value);
        @(negedge i_clk);
        i_hash_seed_we = 1'b1;
        i_hash_seed = value;
        seed_shadow = value;
        @(negedge i_clk);
        i_hash_seed_we = 1'b0;
    endtask

    task automatic send_random_phase(input int n_items);
        int        sent;
        int        kind;
        int        nbytes;
        int        nwords;
        int        w;
        logic      close_msg;
        t_word_txn t;
        sent = 0;
        t.golden_en = 1'b0;
        t.golden = '0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                // well-formed message with random content
                nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 200)
                                                      : $urandom_range(0, 40);
                nwords = (nbytes + WORD_BYTES - 1) / WORD_BYTES;
                if (nwords == 0)
                    nwords = 1;
                for (w = 0; w < nwords; w++) begin
                    t.first = (w == 0);
                    t.len = LEN_W'(nbytes);
                    t.data = {$urandom, $urandom};
                    t.nbytes = (nbytes - WORD_BYTES * w >= WORD_BYTES) ? NBYTES_W'(WORD_BYTES)
                               : NBYTES_W'(nbytes - WORD_BYTES * w);
                    t.last = (w == nwords - 1);
                    send_txn(t);
                end
                sent += nwords;
            end else if (kind == 8) begin
                // broken message: random length field, odd counts, maybe never closed
                nwords = $urandom_range(1, 6);
                close_msg = 1'($urandom);
                for (w = 0; w < nwords; w++) begin
                    t.first = (w == 0);
                    t.len = LEN_W'($urandom);
                    t.data = {$urandom, $urandom};
                    t.nbytes = NBYTES_W'($urandom_range(0, 15));
                    t.last = close_msg && (w == nwords - 1);
                    send_txn(t);
                end
                sent += nwords;
            end else begin
                t.first = 1'($urandom);
                t.len = LEN_W'($urandom);
                t.data = {$urandom, $urandom};
                t.nbytes = NBYTES_W'($urandom_range(0, 15));
                t.last = 1'($urandom);
                send_txn(t);
                sent++;
            end
        end
    endtask

    initial begin
        logic [SEED_W-1:0] seed_plan [N_PHASES];
        seed_plan = '{32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h8000_0001, 32'h0};
        seed_plan[1] = $urandom;
        seed_plan[3] = $urandom;
        seed_plan[5] = $urandom;

        //                first  len           data                    nb     last  gold  value
        directed_tbl = '{
            '{1'b0, 31'd0,         64'h0,                  4'd0,  1'b1, 1'b1, 64'h0},
            '{1'b1, 31'd0,         64'h0,                  4'd0,  1'b1, 1'b1, 64'h0},
            '{1'b1, 31'h7fff_ffff, 64'hffff_ffff_ffff_ffff, 4'd8,  1'b0, 1'b0, 64'h0},
            '{1'b0, 31'd0,         64'hffff_ffff_ffff_ffff, 4'd8,  1'b0, 1'b0, 64'h0},
            '{1'b0, 31'd0,         64'h0,                  4'd8,  1'b0, 1'b0, 64'h0},
            '{1'b0, 31'h7fff_ffff, 64'h0123_4567_89ab_cdef, 4'd7,  1'b1, 1'b0, 64'h0},
            '{1'b1, 31'd9,         64'hdead_beef_cafe_f00d, 4'd8,  1'b0, 1'b0, 64'h0},
            '{1'b0, 31'd0,         64'hffff_ffff_ffff_ffff, 4'd1,  1'b1, 1'b0, 64'h0},
            '{1'b1, 31'd20,        64'hffff_ffff_ffff_ffff, 4'd2,  1'b0, 1'b0, 64'h0},
            '{1'b0, 31'd0,         64'ha5a5_a5a5_a5a5_a5a5, 4'd3,  1'b0, 1'b0, 64'h0},
            '{1'b0, 31'd0,         64'h5a5a_5a5a_5a5a_5a5a, 4'd4,  1'b0, 1'b0, 64'h0},
            '{1'b0, 31'd0,         64'hffff_ffff_ffff_ffff, 4'd5,  1'b0, 1'b0, 64'h0},
            '{1'b0, 31'd0,         64'h8000_0000_0000_0001, 4'd6,  1'b0, 1'b0, 64'h0},
            '{1'b0, 31'd0,         64'hffff_ffff_ffff_ffff, 4'd7,  1'b1, 1'b0, 64'h0},
            '{1'b1, 31'd16,        64'h1122_3344_5566_7788, 4'd9,  1'b0, 1'b0, 64'h0},
            '{1'b0, 31'd0,         64'h8877_6655_4433_2211, 4'd15, 1'b1, 1'b0, 64'h0},
            '{1'b1, 31'd3,         64'hffff_ffff_ffff_ffff, 4'd0,  1'b0, 1'b0, 64'h0},
            '{1'b0, 31'd0,         64'hffff_ffff_ffff_ffff, 4'd0,  1'b1, 1'b0, 64'h0},
            '{1'b1, 31'd8,         64'h0f1e_2d3c_4b5a_6978, 4'd8,  1'b1, 1'b0, 64'h0},
            '{1'b1, 31'd5,         64'hffff_0000_ffff_0000, 4'd12, 1'b1, 1'b0, 64'h0}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // seed still at its reset value for the directed rows
        for (int i = 0; i < N_DIRECTED; i++)
            send_txn(directed_tbl[i]);
        settle_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            write_seed(seed_plan[p]);
            send_random_phase(ITEMS_PER_PHASE);
            settle_idle();
        end

        if (fail_count == 0 && hash_expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
